// File: hdl/fpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the fractional playback cursor.
// Depends on nothing; every other file of the block imports it.
package fpc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FRAC_BITS   = 16;

   localparam int IDX_W  = 24;
   localparam int POS_W  = IDX_W + FRAC_BITS;
   localparam int RATE_W = 24;
   localparam int STEP_W = RATE_W + FRAC_BITS - 16;
   localparam int SIZE_W = 21;
   localparam int ID_W   = 32;
   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;

   localparam logic [2:0] FUNC_ADVANCE  = 3'd0;
   localparam logic [2:0] FUNC_CONSUME  = 3'd1;
   localparam logic [2:0] FUNC_BOUNDARY = 3'd2;
   localparam logic [2:0] FUNC_ENQUEUE  = 3'd3;
   localparam logic [2:0] FUNC_SET_TAIL = 3'd4;

   typedef struct packed {
      logic [2:0]        func;
      logic [23:0]       frame_count;
      logic [ID_W-1:0]   buffer_id;
      logic [SIZE_W-1:0] buffer_frames;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  sample_index;
      logic [IDX_W-1:0]  next_index;
      logic [15:0]       fraction;
      logic              at_end;
      logic              cross_buffer;
      logic              queue_empty;
      logic              at_boundary;
      logic [SIZE_W-1:0] remaining_frames;
      logic              consumed_valid;
      logic [ID_W-1:0]   consumed_id;
      logic              empty_after_pop;
      logic              fire_ended_event;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic execute;
      logic report;
      logic cfg_ready;
   } cmd_type;

   function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] head);
      logic [HEAD_W:0] s;
      s = (HEAD_W + 1)'(head) + (HEAD_W + 1)'(1);
      if (s >= (HEAD_W + 1)'(QUEUE_DEPTH)) begin
         s = '0;
      end
      return s[HEAD_W-1:0];
   endfunction

   function automatic logic [HEAD_W-1:0] slot_of(input logic [HEAD_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
      if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return s[HEAD_W-1:0];
   endfunction

   function automatic logic [15:0] frac16(input logic [POS_W-1:0] pos);
      logic [FRAC_BITS+15:0] w;
      w = {pos[FRAC_BITS-1:0], 16'b0};
      return w[FRAC_BITS+15 -: 16];
   endfunction

   function automatic logic [STEP_W-1:0] step_of(input logic [RATE_W-1:0] rate);
      logic [RATE_W+FRAC_BITS-1:0] w;
      w = {rate, {FRAC_BITS{1'b0}}};
      return w[RATE_W+FRAC_BITS-1:16];
   endfunction

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

endpackage

// File: hdl/fpc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the playback cursor: fetch, execute, status fetch, report.
// Depends on fpc_pkg for the command struct.
module fpc_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output fpc_pkg::cmd_type cmd
);
   import fpc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_SFETCH = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:  state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_SFETCH;
         ST_SFETCH: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.capture   = (state_ff == ST_IDLE) && start;
   assign cmd.fetch     = (state_ff == ST_FETCH) || (state_ff == ST_SFETCH);
   assign cmd.execute   = (state_ff == ST_EXEC);
   assign cmd.report    = (state_ff == ST_REPORT);
   assign cmd.cfg_ready = (state_ff == ST_IDLE) && !start;

endmodule

// File: hdl/fpc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the playback cursor: buffer queue memory, read position, tail and rate registers.
// Depends on fpc_pkg; driven by the commands of fpc_ctrl.
module fpc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  fpc_pkg::cmd_type          cmd,
   input  fpc_pkg::req_type          req,
   input  logic                      csr_valid,
   input  logic [fpc_pkg::RATE_W-1:0] csr_data,
   output logic                      rsp_valid,
   output fpc_pkg::rsp_type          rsp
);
   import fpc_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   req_type           req_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              tail_pending_ff, tail_pending_in;
   logic [SIZE_W-1:0] tail_size_ff, tail_size_in;
   logic [RATE_W-1:0] rate_ff;

   logic              wr_en;
   logic [HEAD_W-1:0] wr_addr;
   entry_type         wr_data;

   logic [IDX_W-1:0]  index;
   logic [IDX_W:0]    adv_next;
   logic [POS_W-1:0]  front_pos;
   logic [POS_W-1:0]  step_pos;
   logic [POS_W:0]    step_sum;
   logic [POS_W-1:0]  frames_pos;
   logic              nonempty;
   logic              empty_after;
   logic              append;
   logic [HEAD_W-1:0] head_next;

   assign index      = pos_ff[POS_W-1:FRAC_BITS];
   assign adv_next   = (IDX_W + 1)'(index) + (IDX_W + 1)'(1);
   assign front_pos  = POS_W'({rd_ff.size, {FRAC_BITS{1'b0}}});
   assign step_pos   = POS_W'(step_of(rate_ff));
   assign step_sum   = {1'b0, pos_ff} + {1'b0, step_pos};
   assign frames_pos = {req_ff.frame_count, {FRAC_BITS{1'b0}}};
   assign nonempty   = (count_ff != '0);
   assign empty_after = (count_ff == CNT_W'(1));
   assign append     = empty_after && tail_pending_ff;
   assign head_next  = head_inc(head_ff);

   always_comb begin
      res_in          = '0;
      pos_in          = pos_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      tail_pending_in = tail_pending_ff;
      tail_size_in    = tail_size_ff;
      wr_en           = 1'b0;
      wr_addr         = slot_of(head_ff, count_ff);
      wr_data         = '{id: req_ff.buffer_id, size: req_ff.buffer_frames};
      case (req_ff.func)
         FUNC_ADVANCE: begin
            if (!nonempty) begin
               res_in.at_end = 1'b1;
            end else begin
               res_in.sample_index = index;
               res_in.next_index   = adv_next[IDX_W-1:0];
               res_in.fraction     = frac16(pos_ff);
               if (adv_next >= (IDX_W + 1)'(rd_ff.size)) begin
                  if ((count_ff > CNT_W'(1)) || tail_pending_ff) begin
                     res_in.next_index   = '0;
                     res_in.cross_buffer = 1'b1;
                  end else begin
                     res_in.next_index = index;
                     res_in.at_end     = (step_sum >= (POS_W + 1)'(front_pos));
                  end
               end
               pos_in = step_sum[POS_W] ? {POS_W{1'b1}} : step_sum[POS_W-1:0];
            end
         end
         FUNC_CONSUME: begin
            pos_in = sat_add(pos_ff, frames_pos);
         end
         FUNC_BOUNDARY: begin
            if (nonempty) begin
               head_in                 = head_next;
               count_in                = count_ff - CNT_W'(1);
               pos_in                  = (pos_ff >= front_pos) ? pos_ff - front_pos : '0;
               res_in.consumed_valid   = 1'b1;
               res_in.consumed_id      = rd_ff.id;
               res_in.empty_after_pop  = empty_after;
               res_in.fire_ended_event = !append;
               if (append) begin
                  wr_en           = 1'b1;
                  wr_addr         = head_next;
                  wr_data         = '{id: rd_ff.id, size: tail_size_ff};
                  count_in        = CNT_W'(1);
                  tail_pending_in = 1'b0;
               end
            end
         end
         FUNC_ENQUEUE: begin
            if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_SET_TAIL: begin
            tail_pending_in = 1'b1;
            tail_size_in    = req_ff.buffer_frames;
         end
         default: begin
         end
      endcase
   end

   // Status is taken after the second fetch, so rd_ff holds the front entry left by this beat.
   always_comb begin
      rsp_in             = res_ff;
      rsp_in.queue_empty = !nonempty;
      if (!nonempty) begin
         rsp_in.at_boundary      = 1'b1;
         rsp_in.remaining_frames = '0;
      end else begin
         rsp_in.at_boundary      = (pos_ff >= front_pos);
         rsp_in.remaining_frames = (index < IDX_W'(rd_ff.size)) ?
                                   rd_ff.size - index[SIZE_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_ff <= mem[head_ff];
      end
      if (cmd.execute && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.execute) begin
         res_ff       <= res_in;
         tail_size_ff <= tail_size_in;
      end
      if (cmd.report) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         head_ff         <= '0;
         count_ff        <= '0;
         tail_pending_ff <= 1'b0;
         rate_ff         <= RATE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.report;
         if (cmd.execute) begin
            pos_ff          <= pos_in;
            head_ff         <= head_in;
            count_ff        <= count_in;
            tail_pending_ff <= tail_pending_in;
         end
         if (csr_valid && cmd.cfg_ready) begin
            rate_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hdl/fractional_playback_cursor.sv
`timescale 1ns / 1ps
// Fractional playback cursor: a queue of audio buffers read by a Q24.16 fixed-point position.
// An accepted beat passes through fetch, execute, status fetch and report; rsp_valid is registered.
// One beat is in flight at a time: busy stays high until the report, so no new beat is taken until
// the last is through; the two queue memory reads (front before and after the update) lie around the update.
// Synchronous active-high reset empties the queue, clears position and tail, and sets rate 1.0.
// Results cannot be stalled; each one is shown for exactly one cycle. Depends on fpc_pkg.
module fractional_playback_cursor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fpc_pkg::req_type           req,
   output logic                       rsp_valid,
   output fpc_pkg::rsp_type           rsp,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fpc_pkg::RATE_W-1:0] csr_data
);
   import fpc_pkg::*;

   cmd_type cmd;

   fpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   fpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign csr_ready = cmd.cfg_ready;

endmodule

// File: hdl/fpc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the playback cursor, bound to the top level.
// Depends on fpc_pkg for the payload types.
module fpc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input fpc_pkg::rsp_type           rsp
);
   import fpc_pkg::*;

   // Every accepted beat gets its result on rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##4 rsp_valid)
      else $error("result missing five cycles after an accepted beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a beat is still in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.queue_empty |-> rsp.at_boundary && (rsp.remaining_frames == '0))
      else $error("empty queue reported with frames left");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.consumed_valid && !rsp.empty_after_pop |-> rsp.fire_ended_event)
      else $error("tail appended although the queue was not empty");

endmodule

bind fractional_playback_cursor fpc_checker u_checker (.*);
